// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- src/totp_pkg.sv -----
// ----------------------------------------------------------------------------
// TOTP package
// Shared types, constants and functions for the TOTP block.
// ----------------------------------------------------------------------------
`default_nettype none
package totp_pkg;

    localparam int DEF_MAX_SECRET_BYTES = 20;
    localparam int DEF_MAX_WINDOW       = 15;
    localparam int CFG_BYTES            = 20;

    localparam logic [2:0] REG_SECRET_A  = 3'd0;
    localparam logic [2:0] REG_SECRET_B  = 3'd1;
    localparam logic [2:0] REG_SECRET_C  = 3'd2;
    localparam logic [2:0] REG_SECRET_LEN = 3'd3;
    localparam logic [2:0] REG_STEP      = 3'd4;
    localparam logic [2:0] REG_DIGITS    = 3'd5;
    localparam logic [2:0] REG_WBACK     = 3'd6;
    localparam logic [2:0] REG_WAHEAD    = 3'd7;

    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_VALIDATE = 1'b1;

    // Control handshake to the SHA-1 core.
    typedef struct packed {
        logic        start;
        logic        first;
    } sha_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_PICK,
        ST_IN1,
        ST_IN2,
        ST_OUT1,
        ST_OUT2,
        ST_TRUNC,
        ST_MOD,
        ST_CHECK,
        ST_DONE
    } state_t;

    function automatic logic [29:0] dec_pow(input logic [3:0] n);
        logic [29:0] r;
        case (n)
            4'd0: r = 30'd1;
            4'd1: r = 30'd10;
            4'd2: r = 30'd100;
            4'd3: r = 30'd1000;
            4'd4: r = 30'd10000;
            4'd5: r = 30'd100000;
            4'd6: r = 30'd1000000;
            4'd7: r = 30'd10000000;
            4'd8: r = 30'd100000000;
            default: r = 30'd1000000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/totp_sha1.sv -----
// ----------------------------------------------------------------------------
// TOTP SHA-1 core
// One 512-bit block compression, one round per cycle, chaining state kept.
// ----------------------------------------------------------------------------
`default_nettype none
module totp_sha1 (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire totp_pkg::sha_ctl_t ctl,
    input  wire logic [511:0]      block,
    output logic                   busy,
    output logic [159:0]           digest
);
    logic [31:0]  h_reg [5];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [511:0] w_reg;
    logic [6:0]   rnd_reg;
    logic         run_reg;
    logic         fin_reg;

    logic [31:0] f, k, t, wn, w_cur;

    assign w_cur = w_reg[511:480];
    assign wn    = w_reg[511-2*32 -: 32] ^ w_reg[511-8*32 -: 32]
                 ^ w_reg[511-13*32 -: 32] ^ w_reg[511 -: 32];

    always_comb
    begin
        if (rnd_reg < 7'd20)
        begin
            f = (b_reg & c_reg) | (~b_reg & d_reg);
            k = 32'h5A827999;
        end
        else if (rnd_reg < 7'd40)
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'h6ED9EBA1;
        end
        else if (rnd_reg < 7'd60)
        begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k = 32'h8F1BBCDC;
        end
        else
        begin
            f = b_reg ^ c_reg ^ d_reg;
            k = 32'hCA62C1D6;
        end
        t = {a_reg[26:0], a_reg[31:27]} + f + e_reg + k + w_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            rnd_reg <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (ctl.start && !run_reg)
            begin
                run_reg <= 1'b1;
                rnd_reg <= '0;
            end
            else if (run_reg)
            begin
                if (rnd_reg == 7'd79)
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
                rnd_reg <= rnd_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start && !run_reg)
        begin
            if (ctl.first)
            begin
                h_reg[0] <= 32'h67452301; h_reg[1] <= 32'hEFCDAB89;
                h_reg[2] <= 32'h98BADCFE; h_reg[3] <= 32'h10325476;
                h_reg[4] <= 32'hC3D2E1F0;
                a_reg <= 32'h67452301; b_reg <= 32'hEFCDAB89;
                c_reg <= 32'h98BADCFE; d_reg <= 32'h10325476;
                e_reg <= 32'hC3D2E1F0;
            end
            else
            begin
                a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2];
                d_reg <= h_reg[3]; e_reg <= h_reg[4];
            end
            w_reg <= block;
        end
        else if (run_reg)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t;
            w_reg <= {w_reg[479:0], wn[30:0], wn[31]};
        end
        else if (fin_reg)
        begin
            h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg;
        end
    end

    assign busy   = run_reg | fin_reg;
    assign digest = {h_reg[0], h_reg[1], h_reg[2], h_reg[3], h_reg[4]};

    `include "assert_macros.svh"
    `ASSERT_NXT(a_fin_after_last, clk, rst_n, run_reg && rnd_reg == 7'd79, fin_reg && !run_reg)
    `ASSERT_IMP(a_no_overlap, clk, rst_n, fin_reg, !run_reg)
endmodule
`default_nettype wire

// ----- src/totp_generate_validate.sv -----
// ----------------------------------------------------------------------------
// TOTP generate and validate
// RFC 6238 one-time passwords over HMAC-SHA1 with a shared round engine.
// ----------------------------------------------------------------------------
// Usage: an item enters on s_axis (tdata = timestamp, then given_code; tuser =
// operation). The block computes counter = timestamp / step_seconds with a
// restoring divider of one quotient bit per cycle, then runs the
// HMAC over the counter using a single SHA-1 round engine that does one
// round per cycle. One code takes four compressions and then the modulo
// reduction by restoring subtraction. Generate computes one code; validate
// computes up to 1 + window_back + window_ahead codes, stopping at the
// first match, so an item computes n codes with n at most 31.
// s_axis_tready is low while an item is in work. The single result item sits
// in an output register on m_axis (tdata = code_value, tuser = match) until
// taken; a new input item may be accepted while it waits, but the next
// result is held back until the register is free. Reset returns all
// configuration registers to their documented defaults and empties the
// output register. Configuration is written through cfg_we/cfg_index.
// ----------------------------------------------------------------------------
`default_nettype none
module totp_generate_validate #(
    parameter int MAX_SECRET_BYTES = totp_pkg::DEF_MAX_SECRET_BYTES,
    parameter int MAX_WINDOW       = totp_pkg::DEF_MAX_WINDOW
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // timestamp [63:0], given_code [93:64], zero fill to 96 bits
    input  wire logic [95:0] s_axis_tdata,
    // operation
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // code_value [29:0], zero fill to 32 bits
    output logic [31:0]      m_axis_tdata,
    // match
    output logic             m_axis_tuser,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    localparam int KEY_LIMIT = (MAX_SECRET_BYTES < totp_pkg::CFG_BYTES) ?
                               MAX_SECRET_BYTES : totp_pkg::CFG_BYTES;
    localparam int WW = 8;

    // Configuration registers.
    logic [63:0] sec_a_reg, sec_b_reg;
    logic [31:0] sec_c_reg, step_reg;
    logic [4:0]  slen_reg;
    logic [3:0]  digits_reg, wback_reg, wahead_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_a_reg <= '0; sec_b_reg <= '0; sec_c_reg <= '0;
            slen_reg <= 5'd20; step_reg <= 32'd30; digits_reg <= 4'd6;
            wback_reg <= 4'd1; wahead_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                totp_pkg::REG_SECRET_A:   sec_a_reg  <= cfg_data;
                totp_pkg::REG_SECRET_B:   sec_b_reg  <= cfg_data;
                totp_pkg::REG_SECRET_C:   sec_c_reg  <= cfg_data[31:0];
                totp_pkg::REG_SECRET_LEN: slen_reg   <= cfg_data[4:0];
                totp_pkg::REG_STEP:       step_reg   <= cfg_data[31:0];
                totp_pkg::REG_DIGITS:     digits_reg <= cfg_data[3:0];
                totp_pkg::REG_WBACK:      wback_reg  <= cfg_data[3:0];
                totp_pkg::REG_WAHEAD:     wahead_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Padded key block: bytes at or past the clamped length are zero.
    logic [159:0] key_raw;
    logic [511:0] key_blk;
    logic [4:0]   klen;
    assign key_raw = {sec_a_reg, sec_b_reg, sec_c_reg};
    assign klen = (slen_reg > 5'(KEY_LIMIT)) ? 5'(KEY_LIMIT) : slen_reg;
    always_comb
    begin
        key_blk = '0;
        for (int i = 0; i < 20; i++)
            if (5'(i) < klen)
                key_blk[511 - 8*i -: 8] = key_raw[159 - 8*i -: 8];
    end

    // Datapath registers.
    totp_pkg::state_t state_reg, state_next;
    logic [63:0]  ts_reg, ctr_reg, cur_ctr_reg;
    logic [31:0]  rem_reg;
    logic [6:0]   cnt_reg;
    logic         op_reg;
    logic [29:0]  given_reg, now_reg, code_reg;
    logic [WW:0]  idx_reg;
    logic         hit_reg, first_reg;
    logic [159:0] inner_reg;
    logic [31:0]  bin_reg;
    logic         out_v_reg;
    logic [29:0]  out_code_reg;
    logic         out_match_reg;

    logic [31:0] step_eff;
    logic [32:0] div_trial;
    logic [WW-1:0] wb_eff, wa_eff;
    assign step_eff  = (step_reg == '0) ? 32'd1 : step_reg;
    assign div_trial = {rem_reg, ts_reg[63]} - {1'b0, step_eff};
    assign wb_eff = ({4'd0, wback_reg} > 8'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : WW'(wback_reg);
    assign wa_eff = ({4'd0, wahead_reg} > 8'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : WW'(wahead_reg);

    // SHA core.
    totp_pkg::sha_ctl_t sha_ctl;
    logic [511:0] sha_blk;
    logic         sha_busy;
    logic [159:0] sha_dig;

    totp_sha1 u_sha (
        .clk(clk), .rst_n(rst_n), .ctl(sha_ctl), .block(sha_blk),
        .busy(sha_busy), .digest(sha_dig)
    );

    always_comb
    begin
        sha_ctl = '0;
        sha_blk = '0;
        case (state_reg)
            totp_pkg::ST_IN1:
            begin
                sha_ctl.start = !sha_busy && !cnt_reg[0];
                sha_ctl.first = 1'b1;
                sha_blk = key_blk ^ {64{8'h36}};
            end
            totp_pkg::ST_IN2:
            begin
                sha_ctl.start = !sha_busy && !cnt_reg[0];
                sha_blk = {cur_ctr_reg, 8'h80, 376'd0, 64'd576};
            end
            totp_pkg::ST_OUT1:
            begin
                sha_ctl.start = !sha_busy && !cnt_reg[0];
                sha_ctl.first = 1'b1;
                sha_blk = key_blk ^ {64{8'h5C}};
            end
            totp_pkg::ST_OUT2:
            begin
                sha_ctl.start = !sha_busy && !cnt_reg[0];
                sha_blk = {inner_reg, 8'h80, 280'd0, 64'd672};
            end
            default: ;
        endcase
    end

    // Dynamic truncation select.
    logic [3:0]  off;
    logic [31:0] trunc;
    assign off = sha_dig[3:0];
    assign trunc = sha_dig[159 - 8*off -: 32] & 32'h7FFFFFFF;

    // Modulo by restoring subtraction of pow << j, j from 31 down.
    logic [29:0] modp;
    logic [62:0] mod_sub;
    logic [3:0]  nd;
    assign nd = (digits_reg > 4'd9) ? 4'd9 : digits_reg;
    assign modp = totp_pkg::dec_pow(nd);
    assign mod_sub = {33'd0, modp} << cnt_reg[4:0];

    // Next candidate counter selection in validate.
    logic last_cand;
    assign last_cand = (idx_reg >= {1'b0, wb_eff} + {1'b0, wa_eff});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            totp_pkg::ST_IDLE:
                if (s_axis_tvalid) state_next = totp_pkg::ST_DIV;
            totp_pkg::ST_DIV:
                if (cnt_reg == 7'd63) state_next = totp_pkg::ST_IN1;
            totp_pkg::ST_PICK:
                if (last_cand) state_next = totp_pkg::ST_DONE;
                else if (idx_reg < {1'b0, wb_eff} && ctr_reg < 64'(idx_reg) + 64'd1)
                    state_next = totp_pkg::ST_PICK;
                else state_next = totp_pkg::ST_IN1;
            totp_pkg::ST_IN1:
                if (cnt_reg[0] && !sha_busy) state_next = totp_pkg::ST_IN2;
            totp_pkg::ST_IN2:
                if (cnt_reg[0] && !sha_busy) state_next = totp_pkg::ST_OUT1;
            totp_pkg::ST_OUT1:
                if (cnt_reg[0] && !sha_busy) state_next = totp_pkg::ST_OUT2;
            totp_pkg::ST_OUT2:
                if (cnt_reg[0] && !sha_busy) state_next = totp_pkg::ST_TRUNC;
            totp_pkg::ST_TRUNC: state_next = totp_pkg::ST_MOD;
            totp_pkg::ST_MOD:
                if (cnt_reg == 7'd0) state_next = totp_pkg::ST_CHECK;
            totp_pkg::ST_CHECK:
                if (op_reg == totp_pkg::OP_GENERATE || code_reg == given_reg)
                    state_next = totp_pkg::ST_DONE;
                else state_next = totp_pkg::ST_PICK;
            totp_pkg::ST_DONE:
                if (!out_v_reg || m_axis_tready) state_next = totp_pkg::ST_IDLE;
            default: state_next = totp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= totp_pkg::ST_IDLE;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == totp_pkg::ST_DONE && (!out_v_reg || m_axis_tready))
                out_v_reg <= 1'b1;
            else if (m_axis_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            totp_pkg::ST_IDLE:
            begin
                ts_reg <= s_axis_tdata[63:0];
                given_reg <= s_axis_tdata[93:64];
                op_reg <= s_axis_tuser;
                rem_reg <= '0;
                cnt_reg <= '0;
                idx_reg <= '0;
                hit_reg <= 1'b0;
                first_reg <= 1'b1;
            end
            totp_pkg::ST_DIV:
            begin
                if (!div_trial[32])
                begin
                    rem_reg <= div_trial[31:0];
                    ctr_reg <= {ctr_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[30:0], ts_reg[63]};
                    ctr_reg <= {ctr_reg[62:0], 1'b0};
                end
                ts_reg <= {ts_reg[62:0], 1'b0};
                if (cnt_reg == 7'd63)
                begin
                    cur_ctr_reg <= div_trial[32] ? {ctr_reg[62:0], 1'b0}
                                                 : {ctr_reg[62:0], 1'b1};
                    cnt_reg <= '0;
                end
                else
                    cnt_reg <= cnt_reg + 7'd1;
            end
            totp_pkg::ST_PICK:
            begin
                cnt_reg <= '0;
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg < {1'b0, wb_eff})
                    cur_ctr_reg <= ctr_reg - 64'(idx_reg) - 64'd1;
                else
                    cur_ctr_reg <= ctr_reg + 64'(idx_reg - {1'b0, wb_eff}) + 64'd1;
            end
            totp_pkg::ST_IN1, totp_pkg::ST_IN2, totp_pkg::ST_OUT1, totp_pkg::ST_OUT2:
            begin
                // cnt bit 0 marks that this compression was launched.
                if (!cnt_reg[0]) cnt_reg <= 7'd1;
                else if (!sha_busy)
                begin
                    cnt_reg <= '0;
                    if (state_reg == totp_pkg::ST_IN2) inner_reg <= sha_dig;
                end
            end
            totp_pkg::ST_TRUNC:
            begin
                bin_reg <= trunc;
                cnt_reg <= 7'd31;
            end
            totp_pkg::ST_MOD:
            begin
                if ({31'd0, bin_reg} >= mod_sub)
                    bin_reg <= bin_reg - mod_sub[31:0];
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                    code_reg <= ({31'd0, bin_reg} >= mod_sub) ?
                                30'(bin_reg - mod_sub[31:0]) : bin_reg[29:0];
            end
            totp_pkg::ST_CHECK:
            begin
                if (first_reg) now_reg <= code_reg;
                first_reg <= 1'b0;
                if (op_reg == totp_pkg::OP_VALIDATE && code_reg == given_reg)
                    hit_reg <= 1'b1;
            end
            totp_pkg::ST_DONE:
            begin
                if (!out_v_reg || m_axis_tready)
                begin
                    out_code_reg <= now_reg;
                    out_match_reg <= hit_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == totp_pkg::ST_IDLE);
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = {2'b00, out_code_reg};
    assign m_axis_tuser  = out_match_reg;

    `include "assert_macros.svh"
    `ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_reg != totp_pkg::ST_IDLE, !s_axis_tready)
    `ASSERT_NXT(a_accept_divides, clk, rst_n, s_axis_tvalid && s_axis_tready,
                state_reg == totp_pkg::ST_DIV)
    `ASSERT_IMP(a_gen_no_match, clk, rst_n,
                state_reg == totp_pkg::ST_DONE && op_reg == totp_pkg::OP_GENERATE, !hit_reg)
endmodule
`default_nettype wire
